// ----- src/fps_pkg.sv -----
// Shared types and constants for the Fenwick prefix-sum table.
package fps_pkg;

    localparam int POS_W   = 11;
    localparam int DELTA_W = 32;
    localparam int SUM_W   = 32;
    localparam int SIZE_W  = 11;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic clr;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic    pos_nz;
        logic    clr_last;
        logic    out_free;
        opcode_t cur_op;
        opcode_t new_op;
    } status_t;

endpackage

// ----- src/fps_ctrl.sv -----
// Controller state machine that sequences clears, tree walks and result pushes.
module fps_ctrl import fps_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    unique case (status.new_op)
                        OP_ADD, OP_QUERY: state_next = ST_WALK;
                        OP_CLEAR:         state_next = ST_CLEAR;
                        default:          state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WALK: begin
                if (!status.pos_nz) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = (status.cur_op == OP_QUERY) ? ST_PUSH : ST_IDLE;
            end
            ST_PUSH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: cmd.clr = 1'b1;
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_WALK:  cmd.step = status.pos_nz;
            ST_DRAIN: cmd     = '0;
            ST_PUSH:  cmd.push = status.out_free;
            default:  cmd     = '0;
        endcase
    end

endmodule

// ----- src/fps_datapath.sv -----
// Datapath: size register, node memory, index stepping, accumulator and result register.
module fps_datapath import fps_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [SIZE_W-1:0]         cfg_data,
    input  opcode_t                   in_opcode,
    input  logic [POS_W-1:0]          in_position,
    input  logic signed [DELTA_W-1:0] in_delta,
    input  cmd_t                      cmd,
    output status_t                   status,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [SUM_W-1:0]          out_sum
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1) + 1;
    localparam int MW = (CW > POS_W) ? CW : POS_W;

    logic [SIZE_W-1:0] size_reg;
    opcode_t           op_reg;
    logic [CW-1:0]     pos_reg;
    logic [CW-1:0]     pos_next;
    logic [WIDTH-1:0]  delta_reg;
    logic [WIDTH-1:0]  acc_reg;
    logic [WIDTH-1:0]  acc_next;
    logic              rd_pend_reg;
    logic [AW-1:0]     wa_reg;
    logic [WIDTH-1:0]  rdata_reg;
    logic [AW-1:0]     clr_reg;
    logic              out_valid_reg;
    logic [SUM_W-1:0]  out_sum_reg;

    logic [WIDTH-1:0] mem [DEPTH];

    logic [MW-1:0]    lim_w;
    logic [MW-1:0]    size_w;
    logic [MW-1:0]    depth_w;
    logic [MW-1:0]    in_pos_w;
    logic [MW-1:0]    start_pos;
    logic [CW-1:0]    lim_c;
    logic [CW-1:0]    lowbit;
    logic [CW-1:0]    pos_up;
    logic [AW-1:0]    rd_addr;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [WIDTH-1:0] mem_wd;

    // Sizes above the table depth behave as the full depth.
    assign size_w   = MW'(size_reg);
    assign depth_w  = MW'(DEPTH);
    assign lim_w    = (size_w > depth_w) ? depth_w : size_w;
    assign lim_c    = CW'(lim_w);
    assign in_pos_w = MW'(in_position);

    // Position zero as the walk index means the walk is over, for both directions.
    always_comb begin
        unique case (in_opcode)
            OP_ADD:   start_pos = (in_pos_w > lim_w) ? '0 : in_pos_w;
            OP_QUERY: start_pos = (in_pos_w > lim_w) ? lim_w : in_pos_w;
            default:  start_pos = '0;
        endcase
    end

    assign lowbit  = pos_reg & (CW'(0) - pos_reg);
    assign pos_up  = pos_reg + lowbit;
    assign rd_addr = AW'(pos_reg - CW'(1));

    always_comb begin
        pos_next = pos_reg;
        if (cmd.load) begin
            pos_next = CW'(start_pos);
        end else if (cmd.step) begin
            if (op_reg == OP_ADD) begin
                pos_next = (pos_up > lim_c) ? '0 : pos_up;
            end else begin
                pos_next = pos_reg - lowbit;
            end
        end
    end

    always_comb begin
        acc_next = acc_reg;
        if (cmd.load) begin
            acc_next = '0;
        end else if (rd_pend_reg && op_reg == OP_QUERY) begin
            acc_next = acc_reg + rdata_reg;
        end
    end

    // The clearing sweep owns the write port; otherwise an add writes back its node.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = wa_reg;
        mem_wd = rdata_reg + delta_reg;
        if (cmd.clr) begin
            mem_we = 1'b1;
            mem_wa = clr_reg;
            mem_wd = '0;
        end else if (rd_pend_reg && op_reg == OP_ADD) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg      <= SIZE_RESET;
            op_reg        <= OP_ADD;
            pos_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                size_reg <= cfg_data;
            end
            if (cmd.load) begin
                op_reg <= in_opcode;
            end
            pos_reg     <= pos_next;
            rd_pend_reg <= cmd.step;
            if (cmd.clr) begin
                clr_reg <= (clr_reg == AW'(DEPTH - 1)) ? '0 : clr_reg + AW'(1);
            end
            if (cmd.push) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (cmd.load) begin
            delta_reg <= WIDTH'(in_delta);
        end
        if (cmd.step) begin
            wa_reg <= rd_addr;
        end
        if (cmd.push) begin
            out_sum_reg <= SUM_W'(acc_reg);
        end
    end

    assign status.pos_nz   = (pos_reg != '0);
    assign status.clr_last = (clr_reg == AW'(DEPTH - 1));
    assign status.out_free = !out_valid_reg || out_ready;
    assign status.cur_op   = op_reg;
    assign status.new_op   = in_opcode;

    assign out_valid = out_valid_reg;
    assign out_sum   = out_sum_reg;

endmodule

// ----- src/fenwick_prefix_sum_table.sv -----
// Top level of the Fenwick prefix-sum table.
//
//  Channel  Direction  Signals                        Beat contents
//  s_       in         s_tvalid s_tready s_tuser      tuser[1:0] opcode
//                      s_tdata                        tdata[10:0] position, [42:11] delta
//  m_       out        m_tvalid m_tready m_tdata      tdata[31:0] prefix_sum
//  cfg_     in         cfg_valid cfg_ready cfg_data   cfg_data[10:0] size_in_use
//
// An add or a query walks k tree nodes, where k is at most log2(DEPTH) + 1; the node
// memory reads one node a cycle during the walk, and an add writes each node back.
// A clear beat sweeps the node memory, writing zero to every entry.
// After reset a clearing pass over every entry runs before s_tready rises.
// A waiting result does not block intake; a finished query holds until the m_ channel
// can take it.
// Configuration writes are taken in every cycle.
module fenwick_prefix_sum_table import fps_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [47:0]         s_tdata,   // position[10:0], delta[42:11], zero[47:43]
    input  logic [1:0]          s_tuser,   // opcode[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SUM_W-1:0]    m_tdata,   // prefix_sum[31:0]
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [SIZE_W-1:0]   cfg_data   // size_in_use[10:0]
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    fps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fps_datapath #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_data    (cfg_data),
        .in_opcode   (opcode_t'(s_tuser)),
        .in_position (s_tdata[10:0]),
        .in_delta    (s_tdata[42:11]),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_sum     (m_tdata)
    );

endmodule

// ----- src/fps_checker.sv -----
// Port-level checker for the Fenwick prefix-sum table, bound to the top level.
module fps_checker import fps_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [1:0]       s_tuser,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [SUM_W-1:0] m_tdata
);

    logic s_beat;
    assign s_beat = s_tvalid && s_tready;

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Reset starts the clearing pass, so no beat is taken right after it.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input accepted right after reset");

    // A clear beat starts a sweep that blocks intake.
    a_clear_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat && s_tuser == OP_CLEAR |=> !s_tready)
        else $error("input accepted during clear sweep");

    // An add or query walks and then drains, so intake stays blocked through both states.
    a_walk_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat && (s_tuser == OP_ADD || s_tuser == OP_QUERY) |=> !s_tready ##1 !s_tready)
        else $error("input accepted during tree walk");

endmodule

bind fenwick_prefix_sum_table fps_checker u_fps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- bench/tb_top.sv -----
// Self-checking bench for the Fenwick prefix-sum table, with its own behavioral tree as checker.
`timescale 1ns / 100ps

module tb_top;
    import fps_pkg::*;

    localparam int TREE_DEPTH  = 1024;
    localparam int CYCLE_LIMIT = 1_000_000;
    // A clear beat walks every entry, so the block may stay busy this long after its last result.
    localparam int SETTLE_CYCLES = TREE_DEPTH + 80;
    localparam int LONG_HOLD     = 400;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         op;
        logic [POS_W-1:0]   pos;
        logic [DELTA_W-1:0] delta;
    } beat_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [47:0]         s_tdata   = '0;
    logic [1:0]          s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [SUM_W-1:0]    m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [SIZE_W-1:0]   cfg_data  = '0;

    // Behavioral copy of the tree and of the size register.
    logic [SUM_W-1:0]    fen_nodes [1:TREE_DEPTH];
    logic [SIZE_W-1:0]   size_reg = SIZE_RESET;

    beat_t               ops_waiting [$];
    logic [SUM_W-1:0]    sums_due [$];

    logic op_taken = 1'b0;
    int   gap_left = 0;
    int   burst_left = 1;
    int   hold_left = 0;
    int   style_left = 0;
    int   rx_style = 0;
    int   long_hold_seq = 0;
    int   long_hold_seen = 0;
    int   cycle_count = 0;
    int   fail_count = 0;
    int   n_add = 0, n_query = 0, n_clear = 0, n_ignored = 0, n_checked = 0, n_cfg = 0;

    fenwick_prefix_sum_table #(
        .DEPTH(TREE_DEPTH),
        .WIDTH(32)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        for (int i = 1; i <= TREE_DEPTH; i++) fen_nodes[i] = '0;
    end

    function automatic int eff_limit(input int size);
        return (size > TREE_DEPTH) ? TREE_DEPTH : size;
    endfunction

    function automatic void fen_add(input int pos, input logic [SUM_W-1:0] amount);
        int lim;
        int p;
        lim = eff_limit(size_reg);
        p = pos;
        if (p == 0) return;
        while (p <= lim) begin
            fen_nodes[p] += amount;
            p += p & -p;
        end
    endfunction

    function automatic logic [SUM_W-1:0] fen_prefix(input int pos);
        int lim;
        int p;
        logic [SUM_W-1:0] acc;
        lim = eff_limit(size_reg);
        p = (pos > lim) ? lim : pos;
        acc = '0;
        while (p != 0) begin
            acc += fen_nodes[p];
            p -= p & -p;
        end
        return acc;
    endfunction

    function automatic void push_beat(input logic [1:0] op, input int pos,
                                      input logic [DELTA_W-1:0] delta);
        beat_t b;
        b.op = op;
        b.pos = POS_W'(pos);
        b.delta = delta;
        ops_waiting.push_back(b);
    endfunction

    // Mostly in-range positions, with zero, the edge of the size and beyond-size positions mixed in.
    function automatic beat_t rand_beat(input int lim, input int clear_permille);
        beat_t b;
        int r;
        r = $urandom_range(0, 999);
        if (r < clear_permille) b.op = OP_CLEAR;
        else if (r < clear_permille + 20) b.op = OP_UNUSED;
        else if (r < 520) b.op = OP_ADD;
        else b.op = OP_QUERY;
        r = $urandom_range(0, 99);
        if (lim == 0) b.pos = POS_W'($urandom_range(0, 2047));
        else if (r < 4) b.pos = '0;
        else if (r < 10) b.pos = POS_W'(lim);
        else if (r < 16) b.pos = POS_W'($urandom_range(lim + 1, 2047));
        else b.pos = POS_W'($urandom_range(1, lim));
        r = $urandom_range(0, 9);
        if (r < 5) b.delta = $urandom;
        else if (r < 9) b.delta = $urandom_range(0, 2000) - 1000;
        else b.delta = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        return b;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(negedge aclk) begin : drive_ops
        beat_t nb;
        if (aresetn && !(s_tvalid && !op_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (ops_waiting.size() != 0) begin
                nb = ops_waiting.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nb.op;
                s_tdata  <= {5'b0, nb.delta, nb.pos};
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: alternates between always ready, scattered stalls and stall bursts.
    always @(negedge aclk) begin : drive_ready
        logic rdy;
        if (long_hold_seen != long_hold_seq) begin
            long_hold_seen = long_hold_seq;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else begin
            if (style_left == 0) begin
                style_left = $urandom_range(20, 200);
                rx_style = $urandom_range(0, 2);
            end
            style_left--;
            case (rx_style)
                0: rdy = 1'b1;
                1: rdy = ($urandom_range(0, 3) != 0);
                default: begin
                    if ($urandom_range(0, 9) == 0) hold_left = $urandom_range(1, 15);
                    rdy = (hold_left == 0);
                end
            endcase
        end
        m_tready <= rdy;
    end

    // Sampling at the rising edge: config writes, results and accepted beats.
    always @(posedge aclk) begin : watch
        logic [SUM_W-1:0] want;
        op_taken = s_tvalid && s_tready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                size_reg = cfg_data;
                n_cfg++;
            end
            if (m_tvalid && m_tready) begin
                if (sums_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat: prefix sum %0d", $signed(m_tdata));
                end else begin
                    want = sums_due.pop_front();
                    n_checked++;
                    if (m_tdata !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("prefix sum mismatch: expected %0d (%h), got %0d (%h)",
                                     $signed(want), want, $signed(m_tdata), m_tdata);
                    end
                end
            end
            if (op_taken) begin
                case (s_tuser)
                    OP_ADD: begin
                        fen_add(int'(s_tdata[POS_W-1:0]), s_tdata[POS_W +: DELTA_W]);
                        n_add++;
                    end
                    OP_QUERY: begin
                        sums_due.push_back(fen_prefix(int'(s_tdata[POS_W-1:0])));
                        n_query++;
                    end
                    OP_CLEAR: begin
                        for (int i = 1; i <= TREE_DEPTH; i++) fen_nodes[i] = '0;
                        n_clear++;
                    end
                    default: n_ignored++;
                endcase
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Waits until every beat is sent and every sum is back, then lets a clear run out.
    task automatic settle();
        while (ops_waiting.size() != 0 || s_tvalid || sums_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        int phase_size [8];
        int phase_items [8];
        int lim;
        phase_size  = '{1, 0, 2047, 13, 1000, 0, 64, 1024};
        phase_items = '{120, 80, 300, 200, 300, 250, 200, 400};
        phase_size[5] = $urandom_range(2, TREE_DEPTH);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed beats at the reset size of 1024.
        push_beat(OP_QUERY, 0, 32'd0);
        push_beat(OP_QUERY, 1024, 32'd0);
        push_beat(OP_ADD, 1, 32'h7fff_ffff);
        push_beat(OP_ADD, 1, 32'd1);
        push_beat(OP_ADD, 1024, 32'h8000_0000);
        push_beat(OP_ADD, 0, 32'd12345);
        push_beat(OP_ADD, 2047, 32'd55);
        push_beat(OP_ADD, 1025, 32'd9);
        push_beat(OP_ADD, 512, 32'hffff_ffff);
        push_beat(OP_QUERY, 1, 32'hffff_ffff);
        push_beat(OP_QUERY, 512, 32'd0);
        push_beat(OP_QUERY, 1024, 32'd0);
        push_beat(OP_QUERY, 2047, 32'd0);
        push_beat(OP_QUERY, 1023, 32'd0);
        push_beat(OP_UNUSED, 1, 32'd100);
        push_beat(OP_QUERY, 1024, 32'd0);
        push_beat(OP_CLEAR, 2047, 32'hffff_ffff);
        push_beat(OP_QUERY, 1024, 32'd0);
        push_beat(OP_ADD, 1023, 32'd5);
        push_beat(OP_ADD, 3, -32'sd3);
        push_beat(OP_QUERY, 1023, 32'd0);
        push_beat(OP_QUERY, 2, 32'd0);
        settle();

        // Random phases, each at its own size; the tree keeps its contents across size changes.
        for (int ph = 0; ph < 8; ph++) begin
            @(negedge aclk);
            cfg_valid <= 1'b1;
            cfg_data  <= SIZE_W'(phase_size[ph]);
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            @(negedge aclk);
            cfg_valid <= 1'b0;

            lim = eff_limit(phase_size[ph]);
            for (int i = 0; i < phase_items[ph]; i++)
                ops_waiting.push_back(rand_beat(lim, 10));
            // Stall the result side for a long stretch so the block backs up into its input.
            if (ph == 2) long_hold_seq++;
            settle();
        end

        $display("Covered %0d adds, %0d queries, %0d clears and %0d ignored beats over %0d sizes.",
                 n_add, n_query, n_clear, n_ignored, n_cfg + 1);
        $display("Checked %0d prefix sums; %0d failures.", n_checked, fail_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/fps_pkg.sv
src/fps_ctrl.sv
src/fps_datapath.sv
src/fenwick_prefix_sum_table.sv
src/fps_checker.sv
bench/tb_top.sv
